### hw/rtl/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg: shared types and helpers for the three-component vector ALU
// Holds the component width, the action codes, the transfer payload structs
// and the saturation helper used by the lanes and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package v3a_pkg;

	// Width of one vector component and of the scalar, signed fixed point.
	localparam int unsigned CW = 32;
	// Default number of fraction bits.
	localparam int unsigned FRAC_BITS = 16;
	// Width of the widest intermediate that is saturated down to CW bits.
	localparam int unsigned SATW = 2 * CW + 2;

	typedef enum logic [2:0] {
		ACT_ADD,
		ACT_SUB,
		ACT_SCALE,
		ACT_DIV,
		ACT_DOT,
		ACT_MAG,
		ACT_CROSS,
		ACT_NORM
	} action_t;

	typedef struct packed {
		action_t               action;
		logic signed [CW-1:0]  vec_a_x;
		logic signed [CW-1:0]  vec_a_y;
		logic signed [CW-1:0]  vec_a_z;
		logic signed [CW-1:0]  vec_b_x;
		logic signed [CW-1:0]  vec_b_y;
		logic signed [CW-1:0]  vec_b_z;
		logic signed [CW-1:0]  scalar_in;
	} item_t;

	typedef struct packed {
		logic signed [CW-1:0]  result_x;
		logic signed [CW-1:0]  result_y;
		logic signed [CW-1:0]  result_z;
		logic signed [CW-1:0]  scalar_out;
		logic                  error_flag;
	} result_t;

	// Clamp a wide signed value to the signed CW-bit range.
	function automatic logic signed [CW-1:0] sat_w(input logic signed [SATW-1:0] v);
		logic fits;
		logic signed [CW-1:0] r;
		fits = (&v[SATW-1:CW-1]) | ~(|v[SATW-1:CW-1]);
		if (fits) begin
			r = v[CW-1:0];
		end else if (v[SATW-1]) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = {1'b0, {(CW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/v3a_delay.sv
// ----------------------------------------------------------------------------
// v3a_delay: enabled delay line
// Carries side data alongside a pipelined unit so that it leaves in step.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_delay #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] din,
	output logic      [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

`default_nettype wire

### hw/rtl/v3a_lane.sv
// ----------------------------------------------------------------------------
// v3a_lane: one component lane of the vector ALU
// Selects multiplier operands for the action, multiplies in the first stage
// and forms the saturated per-component result in the second stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_lane #(
	parameter int unsigned FRACTION_BITS = v3a_pkg::FRAC_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire v3a_pkg::action_t                  action,
	input  wire logic signed [v3a_pkg::CW-1:0]     a,
	input  wire logic signed [v3a_pkg::CW-1:0]     b,
	input  wire logic signed [v3a_pkg::CW-1:0]     a_j,
	input  wire logic signed [v3a_pkg::CW-1:0]     b_k,
	input  wire logic signed [v3a_pkg::CW-1:0]     a_k,
	input  wire logic signed [v3a_pkg::CW-1:0]     b_j,
	input  wire logic signed [v3a_pkg::CW-1:0]     s,
	input  wire v3a_pkg::action_t                  act_s1,
	output logic signed [2*v3a_pkg::CW-1:0]        p_s1,
	output logic signed [v3a_pkg::CW-1:0]          rv_s2
);

	localparam int unsigned CW   = v3a_pkg::CW;
	localparam int unsigned SATW = v3a_pkg::SATW;

	logic signed [CW-1:0]     m0, m1, m2, m3;
	logic signed [CW:0]       ab;
	logic signed [2*CW-1:0]   q_s1;
	logic signed [CW:0]       ab_s1;
	logic signed [SATW-1:0]   scale_w;
	logic signed [SATW-1:0]   cross_w;

	always_comb begin
		m0 = '0;
		m1 = '0;
		m2 = '0;
		m3 = '0;
		case (action)
			v3a_pkg::ACT_SCALE: begin
				m0 = a;
				m1 = s;
			end
			v3a_pkg::ACT_DOT: begin
				m0 = a;
				m1 = b;
			end
			v3a_pkg::ACT_MAG, v3a_pkg::ACT_NORM: begin
				m0 = a;
				m1 = a;
			end
			v3a_pkg::ACT_CROSS: begin
				m0 = a_j;
				m1 = b_k;
				m2 = a_k;
				m3 = b_j;
			end
			default: begin
				m0 = '0;
			end
		endcase
	end

	assign ab = (action == v3a_pkg::ACT_SUB) ? ((CW+1)'(a) - (CW+1)'(b))
	                                         : ((CW+1)'(a) + (CW+1)'(b));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= m0 * m1;
			q_s1  <= m2 * m3;
			ab_s1 <= ab;
		end
	end

	assign scale_w = SATW'(p_s1) >>> FRACTION_BITS;
	assign cross_w = (SATW'(p_s1) - SATW'(q_s1)) >>> FRACTION_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			case (act_s1)
				v3a_pkg::ACT_ADD, v3a_pkg::ACT_SUB: rv_s2 <= v3a_pkg::sat_w(SATW'(ab_s1));
				v3a_pkg::ACT_SCALE:                 rv_s2 <= v3a_pkg::sat_w(scale_w);
				v3a_pkg::ACT_CROSS:                 rv_s2 <= v3a_pkg::sat_w(cross_w);
				default:                            rv_s2 <= '0;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/v3a_isqrt.sv
// ----------------------------------------------------------------------------
// v3a_isqrt: pipelined integer square root
// One result bit per stage, most significant first, on a sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_isqrt (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [2*v3a_pkg::CW-1:0]      sumsq,
	output logic      [v3a_pkg::CW-1:0]        root
);

	localparam int unsigned CW = v3a_pkg::CW;

	logic [2*CW-1:0] rem_q  [CW];
	logic [CW-1:0]   root_q [CW];

	for (genvar k = 0; k < CW; k++) begin : g_stage
		localparam int unsigned B = CW - 1 - k;
		logic [2*CW-1:0] rem_in;
		logic [CW-1:0]   root_in;
		logic [2*CW:0]   trial;
		logic            take;

		if (k == 0) begin : g_first
			assign rem_in  = sumsq;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
		end

		// (root + 2^B)^2 - root^2, with root clear below bit B+1.
		assign trial = ((2*CW+1)'(root_in) << (B + 1)) | ((2*CW+1)'(1) << (2 * B));
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= take ? (rem_in - trial[2*CW-1:0]) : rem_in;
				root_q[k] <= take ? (root_in | (CW'(1) << B)) : root_in;
			end
		end
	end

	assign root = root_q[CW-1];

endmodule

`default_nettype wire

### hw/rtl/v3a_div_lane.sv
// ----------------------------------------------------------------------------
// v3a_div_lane: pipelined restoring divider for one component
// Divides the shifted magnitude of a component by a positive divisor, one
// quotient bit per stage, and carries the sign to the end.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_div_lane #(
	parameter int unsigned FRACTION_BITS = v3a_pkg::FRAC_BITS
) (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire logic signed [v3a_pkg::CW-1:0]           a,
	input  wire logic        [v3a_pkg::CW-1:0]           d,
	output logic [v3a_pkg::CW+FRACTION_BITS-1:0]         quo,
	output logic                                         neg
);

	localparam int unsigned CW = v3a_pkg::CW;
	localparam int unsigned N  = CW + FRACTION_BITS;

	logic [CW-1:0] abs_a;
	logic [N-1:0]  num;

	logic [N-1:0]  rq_q  [N];
	logic [CW-1:0] r_q   [N];
	logic [CW-1:0] d_q   [N];
	logic          neg_q [N];

	assign abs_a = a[CW-1] ? (CW'(0) - CW'(a)) : CW'(a);
	assign num   = {abs_a, {FRACTION_BITS{1'b0}}};

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N-1:0]  rq_in;
		logic [CW-1:0] r_in;
		logic [CW-1:0] d_in;
		logic          neg_in;
		logic [CW:0]   sh;
		logic          ge;

		if (k == 0) begin : g_first
			assign rq_in  = num;
			assign r_in   = '0;
			assign d_in   = d;
			assign neg_in = a[CW-1];
		end else begin : g_next
			assign rq_in  = rq_q[k-1];
			assign r_in   = r_q[k-1];
			assign d_in   = d_q[k-1];
			assign neg_in = neg_q[k-1];
		end

		// Numerator bits leave at the top while quotient bits enter at the bottom.
		assign sh = {r_in, rq_in[N-1]};
		assign ge = sh >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]   <= ge ? CW'(sh - {1'b0, d_in}) : sh[CW-1:0];
				rq_q[k]  <= {rq_in[N-2:0], ge};
				d_q[k]   <= d_in;
				neg_q[k] <= neg_in;
			end
		end
	end

	assign quo = rq_q[N-1];
	assign neg = neg_q[N-1];

endmodule

`default_nettype wire

### hw/rtl/three_d_vector_alu.sv
// ----------------------------------------------------------------------------
// three_d_vector_alu: three-component signed fixed-point vector ALU
//
// Items arrive on the item channel (item_valid / item_ready / item) and each
// produces exactly one transfer on the result channel (result_valid /
// result_ready / result). Actions: add, subtract, scale, divide by scalar,
// dot product, magnitude, cross product and normalize. Every value is
// saturated to the signed component range; a divide by a non-positive
// scalar or a normalize of a zero vector sets error_flag with zero results.
//
// The block is a fixed pipeline. Three lanes, one per component, multiply
// in the first stage and form per-component results in the second. A bit-
// per-stage square root (32 stages) follows, then three bit-per-stage
// dividers (32 + FRACTION_BITS stages), then the output register. The block
// takes one item per cycle unless a stalled output register holds back a
// full last stage, as set by the one-stage-per-bit root and divider.
//
// When the receiver stalls, the pipeline keeps advancing as long as its
// last stage holds no item, so bubbles close up and new items are still
// taken while a finished result waits. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module three_d_vector_alu #(
	parameter int unsigned FRACTION_BITS = v3a_pkg::FRAC_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire v3a_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output v3a_pkg::result_t      result
);

	localparam int unsigned CW   = v3a_pkg::CW;
	localparam int unsigned SATW = v3a_pkg::SATW;
	localparam int unsigned N    = CW + FRACTION_BITS;
	// Pipeline registers ahead of the output register.
	localparam int unsigned LAT  = 2 + CW + N;

	// Side data that waits while the square root runs.
	typedef struct packed {
		v3a_pkg::action_t    action;
		logic [2:0][CW-1:0]  a;
		logic [CW-1:0]       s;
		logic [2:0][CW-1:0]  rv;
		logic [CW-1:0]       dot;
	} side1_t;

	// Side data that waits while the dividers run.
	typedef struct packed {
		v3a_pkg::action_t    action;
		logic [2:0][CW-1:0]  rv;
		logic [CW-1:0]       scalar;
		logic                err;
	} side2_t;

	logic                    en;
	logic [LAT-1:0]          v_q;
	logic                    result_valid_q;
	v3a_pkg::result_t        result_q;

	logic signed [CW-1:0]    a_in [3];
	logic signed [CW-1:0]    b_in [3];
	v3a_pkg::item_t          item_s1;
	v3a_pkg::item_t          item_s2;
	logic signed [2*CW-1:0]  p_s1 [3];
	logic signed [CW-1:0]    rv_s2 [3];
	logic signed [SATW-1:0]  sum_s2;

	side1_t                  side1_in, side1_d;
	side2_t                  side2_in, side2_d;
	logic [CW-1:0]           mag;
	logic [CW-1:0]           divisor;
	logic [N-1:0]            quo [3];
	logic                    quo_neg [3];
	logic signed [N:0]       qs [3];
	v3a_pkg::result_t        result_d;

	// The pipeline advances unless a finished item would be pushed into a
	// stalled output register.
	assign en         = result_ready | ~result_valid_q | ~v_q[LAT-1];
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_q <= {v_q[LAT-2:0], item_valid};
			end
			if (!result_valid_q || result_ready) begin
				result_valid_q <= v_q[LAT-1];
			end
		end
	end

	assign a_in[0] = item.vec_a_x;
	assign a_in[1] = item.vec_a_y;
	assign a_in[2] = item.vec_a_z;
	assign b_in[0] = item.vec_b_x;
	assign b_in[1] = item.vec_b_y;
	assign b_in[2] = item.vec_b_z;

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
			item_s2 <= item_s1;
		end
	end

	// Component lanes; each lane also owns one term of the cross product.
	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3a_lane #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_lane (
			.clk   (clk),
			.en    (en),
			.action(item.action),
			.a     (a_in[i]),
			.b     (b_in[i]),
			.a_j   (a_in[(i+1)%3]),
			.b_k   (b_in[(i+2)%3]),
			.a_k   (a_in[(i+2)%3]),
			.b_j   (b_in[(i+1)%3]),
			.s     (item.scalar_in),
			.act_s1(item_s1.action),
			.p_s1  (p_s1[i]),
			.rv_s2 (rv_s2[i])
		);
	end

	// Merge the lane products: dot product or sum of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SATW'(p_s1[0]) + SATW'(p_s1[1]) + SATW'(p_s1[2]);
		end
	end

	v3a_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.sumsq(sum_s2[2*CW-1:0]),
		.root (mag)
	);

	always_comb begin
		side1_in.action = item_s2.action;
		side1_in.a[0]   = item_s2.vec_a_x;
		side1_in.a[1]   = item_s2.vec_a_y;
		side1_in.a[2]   = item_s2.vec_a_z;
		side1_in.s      = item_s2.scalar_in;
		side1_in.rv[0]  = rv_s2[0];
		side1_in.rv[1]  = rv_s2[1];
		side1_in.rv[2]  = rv_s2[2];
		side1_in.dot    = v3a_pkg::sat_w(sum_s2 >>> FRACTION_BITS);
	end

	v3a_delay #(
		.WIDTH($bits(side1_t)),
		.DEPTH(CW)
	) u_delay_root (
		.clk (clk),
		.en  (en),
		.din (side1_in),
		.dout(side1_d)
	);

	// Divide uses the scalar, normalize the magnitude.
	assign divisor = (side1_d.action == v3a_pkg::ACT_DIV) ? side1_d.s : mag;

	always_comb begin
		side2_in.action = side1_d.action;
		side2_in.rv     = side1_d.rv;
		case (side1_d.action)
			v3a_pkg::ACT_DOT: side2_in.scalar = side1_d.dot;
			v3a_pkg::ACT_MAG: side2_in.scalar = v3a_pkg::sat_w({{(SATW-CW){1'b0}}, mag});
			default:          side2_in.scalar = '0;
		endcase
		case (side1_d.action)
			v3a_pkg::ACT_DIV:  side2_in.err = side1_d.s[CW-1] | (side1_d.s == '0);
			v3a_pkg::ACT_NORM: side2_in.err = (mag == '0);
			default:           side2_in.err = 1'b0;
		endcase
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		v3a_div_lane #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_div (
			.clk(clk),
			.en (en),
			.a  (signed'(side1_d.a[i])),
			.d  (divisor),
			.quo(quo[i]),
			.neg(quo_neg[i])
		);

		assign qs[i] = quo_neg[i] ? -signed'({1'b0, quo[i]}) : signed'({1'b0, quo[i]});
	end

	v3a_delay #(
		.WIDTH($bits(side2_t)),
		.DEPTH(N)
	) u_delay_div (
		.clk (clk),
		.en  (en),
		.din (side2_in),
		.dout(side2_d)
	);

	// Final selection by action; an error zeroes every value field.
	always_comb begin
		result_d.result_x   = '0;
		result_d.result_y   = '0;
		result_d.result_z   = '0;
		result_d.scalar_out = '0;
		result_d.error_flag = side2_d.err;
		if (!side2_d.err) begin
			case (side2_d.action)
				v3a_pkg::ACT_DIV, v3a_pkg::ACT_NORM: begin
					result_d.result_x = v3a_pkg::sat_w(SATW'(qs[0]));
					result_d.result_y = v3a_pkg::sat_w(SATW'(qs[1]));
					result_d.result_z = v3a_pkg::sat_w(SATW'(qs[2]));
				end
				v3a_pkg::ACT_DOT, v3a_pkg::ACT_MAG: begin
					result_d.scalar_out = side2_d.scalar;
				end
				default: begin
					result_d.result_x = side2_d.rv[0];
					result_d.result_y = side2_d.rv[1];
					result_d.result_z = side2_d.rv[2];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (!result_valid_q || result_ready) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### test/v3a_checker.sv
// ----------------------------------------------------------------------------
// v3a_checker: result predictor and scoreboard for the vector ALU
// Watches both channels, computes the expected result of every accepted item
// and compares each result transfer against the oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_ready,
	input  wire v3a_pkg::item_t   item,
	input  wire logic             result_valid,
	input  wire logic             result_ready,
	input  wire v3a_pkg::result_t result,
	output int                    errors,
	output int                    pending,
	output int                    results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          FB = v3a_pkg::FRAC_BITS;
	localparam int unsigned CW = v3a_pkg::CW;

	v3a_pkg::result_t expected_results[$];

	function automatic logic signed [CW-1:0] clamp(input logic signed [191:0] v);
		logic signed [191:0] hi_lim;
		logic signed [191:0] lo_lim;
		hi_lim = (192'sd1 <<< (CW - 1)) - 1;
		lo_lim = -(192'sd1 <<< (CW - 1));
		if (v > hi_lim) return hi_lim[CW-1:0];
		if (v < lo_lim) return lo_lim[CW-1:0];
		return v[CW-1:0];
	endfunction

	// Quotient truncated toward zero; divisor is always positive here.
	function automatic logic signed [191:0] quot(input logic signed [191:0] n,
		input logic signed [191:0] d);
		logic signed [191:0] q;
		q = (n < 0) ? -n : n;
		q = q / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic logic signed [191:0] floor_root(input logic signed [191:0] s);
		logic signed [191:0] r;
		logic signed [191:0] c;
		r = 0;
		for (int b = CW; b >= 0; b--) begin
			c = r | (192'sd1 <<< b);
			if (c * c <= s) r = c;
		end
		return r;
	endfunction

	function automatic v3a_pkg::result_t vector_result(input v3a_pkg::item_t it);
		v3a_pkg::result_t r;
		logic signed [191:0] a[3];
		logic signed [191:0] b[3];
		logic signed [191:0] s;
		logic signed [191:0] v[3];
		logic signed [191:0] sq;
		logic signed [191:0] m;
		a[0] = it.vec_a_x; a[1] = it.vec_a_y; a[2] = it.vec_a_z;
		b[0] = it.vec_b_x; b[1] = it.vec_b_y; b[2] = it.vec_b_z;
		s = it.scalar_in;
		r = '0;
		for (int i = 0; i < 3; i++) v[i] = 0;
		sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		case (it.action)
			v3a_pkg::ACT_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
			v3a_pkg::ACT_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
			v3a_pkg::ACT_SCALE: for (int i = 0; i < 3; i++) v[i] = (a[i] * s) >>> FB;
			v3a_pkg::ACT_DIV: begin
				if (s <= 0) r.error_flag = 1'b1;
				else for (int i = 0; i < 3; i++) v[i] = quot(a[i] <<< FB, s);
			end
			v3a_pkg::ACT_DOT:
				r.scalar_out = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB);
			v3a_pkg::ACT_MAG: r.scalar_out = clamp(floor_root(sq));
			v3a_pkg::ACT_CROSS: begin
				v[0] = (a[1] * b[2] - a[2] * b[1]) >>> FB;
				v[1] = (a[2] * b[0] - a[0] * b[2]) >>> FB;
				v[2] = (a[0] * b[1] - a[1] * b[0]) >>> FB;
			end
			default: begin
				m = floor_root(sq);
				if (m == 0) r.error_flag = 1'b1;
				else for (int i = 0; i < 3; i++) v[i] = quot(a[i] <<< FB, m);
			end
		endcase
		if (it.action != v3a_pkg::ACT_DOT && it.action != v3a_pkg::ACT_MAG
			&& !r.error_flag) begin
			r.result_x = clamp(v[0]);
			r.result_y = clamp(v[1]);
			r.result_z = clamp(v[2]);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		v3a_pkg::result_t exp_r;
		if (!arst_n) begin
			errors <= 0;
			results_seen <= 0;
			pending <= 0;
			expected_results.delete();
		end else begin
			if (item_valid && item_ready) expected_results.push_back(vector_result(item));
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result transfer with no item outstanding");
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r !== result) begin
						errors <= errors + 1;
						if (exp_r.result_x !== result.result_x)
							$error("result_x expected %0d got %0d", exp_r.result_x, result.result_x);
						if (exp_r.result_y !== result.result_y)
							$error("result_y expected %0d got %0d", exp_r.result_y, result.result_y);
						if (exp_r.result_z !== result.result_z)
							$error("result_z expected %0d got %0d", exp_r.result_z, result.result_z);
						if (exp_r.scalar_out !== result.scalar_out)
							$error("scalar_out expected %0d got %0d", exp_r.scalar_out,
								result.scalar_out);
						if (exp_r.error_flag !== result.error_flag)
							$error("error_flag expected %0b got %0b", exp_r.error_flag,
								result.error_flag);
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench for the three-component vector ALU
// Drives directed corner items and then random bursts with random idle gaps,
// stalls the result side on its own pattern, and reports the checker's count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CW = v3a_pkg::CW;
	localparam int RANDOM_ITEMS = 1250;
	// The idle watchdog allows generous margin over the pipeline depth
	// plus the longest receiver stall.
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	v3a_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	v3a_pkg::result_t result;
	int               errors;
	int               pending;
	int               results_seen;
	int               idle_cycles = 0;
	int               items_sent;

	three_d_vector_alu u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	v3a_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A mix of corner values so that saturation, zero and sign boundaries are
	// hit often, with fully random words the rest of the time.
	function automatic logic signed [CW-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 0;
			3: return $signed($urandom_range(0, 8)) - 4;
			4: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			5: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic v3a_pkg::item_t random_item();
		v3a_pkg::item_t it;
		it.action = v3a_pkg::action_t'($urandom_range(0, 7));
		it.vec_a_x = pick_value(); it.vec_a_y = pick_value(); it.vec_a_z = pick_value();
		it.vec_b_x = pick_value(); it.vec_b_y = pick_value(); it.vec_b_z = pick_value();
		it.scalar_in = pick_value();
		// Every action, normalize and divide included, gets a zero vector a now and then.
		if ($urandom_range(0, 15) == 0) begin
			it.vec_a_x = 0; it.vec_a_y = 0; it.vec_a_z = 0;
		end
		return it;
	endfunction

	// Present one item and hold it until the transfer happens.
	task automatic send(input v3a_pkg::item_t it);
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic gap(input int n);
		item_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_all(input v3a_pkg::item_t it, input logic signed [CW-1:0] v);
		it.vec_a_x = v; it.vec_a_y = v; it.vec_a_z = v;
		it.vec_b_x = v; it.vec_b_y = v; it.vec_b_z = v;
		it.scalar_in = v;
		send(it);
	endtask

	// Receiver stall pattern: long ready stretches, short stalls, and
	// occasional long stalls to let the pipeline fill and back up.
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			result_ready <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
				: $urandom_range(1, 4)) @(posedge clk);
		end
	end

	// Watchdog on cycles in which no transfer happens on either channel.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		v3a_pkg::item_t it;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every action on the extreme values, plus a
		// non-positive divisor and a zero vector under normalize.
		for (int a = 0; a < 8; a++) begin
			it = '0;
			it.action = v3a_pkg::action_t'(a);
			send_all(it, 32'sh7fff_ffff);
			send_all(it, 32'sh8000_0000);
		end
		it = '0;
		it.action = v3a_pkg::ACT_DIV;
		it.vec_a_x = 32'sh0001_0000;
		send(it);
		it.scalar_in = -1;
		send(it);
		it.scalar_in = 1;
		send(it);
		it = '0;
		it.action = v3a_pkg::ACT_NORM;
		send(it);
		it.vec_a_x = 32'sh0003_0000;
		it.vec_a_y = 32'sh0004_0000;
		send(it);
		it.vec_a_x = 1;
		it.vec_a_y = 0;
		send(it);

		// Let the pipeline drain completely once before the random part.
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		// Random bursts with random gaps; some bursts run without any idling.
		while (items_sent < 22 + RANDOM_ITEMS) begin
			repeat ($urandom_range(1, 30)) send(random_item());
			if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
		end
		item_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items across all eight actions, saturation corners,",
			items_sent);
		$display("non-positive divisors and zero-vector normalize; %0d results checked.",
			results_seen);
		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/v3a_pkg.sv
hw/rtl/v3a_delay.sv
hw/rtl/v3a_lane.sv
hw/rtl/v3a_isqrt.sv
hw/rtl/v3a_div_lane.sv
hw/rtl/three_d_vector_alu.sv
test/v3a_checker.sv
test/tb.sv
